>>> design/rsd_pkg.sv
// Shared constants and types for the raw sample to binary64 unpack core.
package rsd_pkg;

    localparam logic [1:0] REG_WORD_SIZE = 2'd0;
    localparam logic [1:0] REG_IS_FLOAT  = 2'd1;

    localparam logic [3:0] SIZE_1B = 4'd1;
    localparam logic [3:0] SIZE_2B = 4'd2;
    localparam logic [3:0] SIZE_4B = 4'd4;
    localparam logic [3:0] SIZE_8B = 4'd8;

    localparam logic [3:0]  WORD_SIZE_RESET = SIZE_2B;
    // 1023 bias plus 63, the exponent of a magnitude whose top bit is bit 63
    localparam logic signed [12:0] EXP_TOP = 13'sd1086;

    typedef struct packed {
        logic               pass;     // result is pass_val as is
        logic [63:0]        pass_val;
        logic               neg;
        logic [63:0]        mag;
        logic signed [11:0] scale;    // value = mag * 2^scale
    } rsd_num_t;

endpackage

>>> design/raw_sample_to_double_unpack_core.sv
// Raw sample to binary64 unpack core: int8/16/32/64 and binary16/32/64 to binary64.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | s_tdata[63:0] raw_word
//  m_      | out | m_tvalid/m_tready | m_tdata[63:0] value_bits
//  cfg_    | in  | cfg_we            | cfg_index, cfg_wdata
//
// One word per cycle through four register stages: input register, format decode,
// leading-zero count, then normalize/round into the output register. An accepted
// word passes raw_reg, num_reg, num3_reg/lzc_reg and m_tdata_reg in that order.
// All stages advance together whenever the output register is empty or taken.
// aresetn (synchronous) clears the valid bits and resets the configuration registers.
module raw_sample_to_double_unpack_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // raw_word[63:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // value_bits[63:0]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_wdata
);
    import rsd_pkg::*;

    logic [3:0]  word_size_reg;
    logic        is_float_reg;
    logic        v1_reg, v2_reg, v3_reg, m_tvalid_reg;
    logic [63:0] raw_reg;
    rsd_num_t    num_next, num_reg, num3_reg;
    logic [5:0]  lzc_next, lzc_reg;
    logic [63:0] m_tdata_reg, m_tdata_next;
    logic        adv;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_size_reg <= WORD_SIZE_RESET;
            is_float_reg  <= 1'b0;
        end else if (cfg_we) begin
            if (cfg_index == REG_WORD_SIZE) word_size_reg <= cfg_wdata;
            else if (cfg_index == REG_IS_FLOAT) is_float_reg <= cfg_wdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            m_tvalid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            raw_reg     <= s_tdata;
            num_reg     <= num_next;
            num3_reg    <= num_reg;
            lzc_reg     <= lzc_next;
            m_tdata_reg <= m_tdata_next;
        end
    end

    // decode the sample into sign, magnitude and scale
    always_comb begin
        logic [63:0] sx;
        logic [4:0]  hex;
        logic [7:0]  sex;
        num_next = '0;
        sx  = '0;
        hex = raw_reg[14:10];
        sex = raw_reg[30:23];
        if (is_float_reg) begin
            case (word_size_reg)
                SIZE_2B: begin
                    num_next.neg = raw_reg[15];
                    if (hex == 5'd0) begin
                        num_next.mag   = {54'd0, raw_reg[9:0]};
                        num_next.scale = -12'sd24;
                    end else begin
                        num_next.mag   = {53'd0, 1'b1, raw_reg[9:0]};
                        num_next.scale = $signed({7'd0, hex}) - 12'sd25;
                    end
                end
                SIZE_4B: begin
                    num_next.neg = raw_reg[31];
                    if (sex == 8'hff) begin
                        num_next.pass     = 1'b1;
                        num_next.pass_val = {raw_reg[31], 11'h7ff,
                                             {raw_reg[22:0], 29'd0} |
                                             {(raw_reg[22:0] != 23'd0), 51'd0}};
                    end else if (sex == 8'd0) begin
                        num_next.mag   = {41'd0, raw_reg[22:0]};
                        num_next.scale = -12'sd149;
                    end else begin
                        num_next.mag   = {40'd0, 1'b1, raw_reg[22:0]};
                        num_next.scale = $signed({4'd0, sex}) - 12'sd150;
                    end
                end
                SIZE_8B: begin
                    num_next.pass     = 1'b1;
                    num_next.pass_val = raw_reg;
                end
                default: num_next.pass = 1'b1;
            endcase
        end else begin
            case (word_size_reg)
                SIZE_1B: sx = {{56{raw_reg[7]}}, raw_reg[7:0]};
                SIZE_2B: sx = {{48{raw_reg[15]}}, raw_reg[15:0]};
                SIZE_4B: sx = {{32{raw_reg[31]}}, raw_reg[31:0]};
                SIZE_8B: sx = raw_reg;
                default: num_next.pass = 1'b1;
            endcase
            num_next.neg = sx[63];
            num_next.mag = sx[63] ? (~sx + 64'd1) : sx;
        end
    end

    // leading-zero count of the magnitude
    always_comb begin
        lzc_next = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (num_reg.mag[i]) lzc_next = 6'(63 - i);
        end
    end

    // normalize, round to nearest even, pack
    always_comb begin
        logic [63:0]        sh;
        logic [53:0]        keep;
        logic               up;
        logic signed [12:0] e;
        sh   = num3_reg.mag << lzc_reg;
        up   = sh[10] && ((|sh[9:0]) || sh[11]);
        keep = {1'b0, sh[63:11]} + {53'd0, up};
        e    = EXP_TOP - $signed({7'd0, lzc_reg}) + 13'(num3_reg.scale)
               + $signed({12'd0, keep[53]});
        if (num3_reg.pass) m_tdata_next = num3_reg.pass_val;
        else if (num3_reg.mag == 64'd0) m_tdata_next = {num3_reg.neg, 63'd0};
        else if (keep[53]) m_tdata_next = {num3_reg.neg, e[10:0], 52'd0};
        else m_tdata_next = {num3_reg.neg, e[10:0], keep[51:0]};
    end

endmodule

>>> design/rsd_checker.sv
// Port-level checker for the unpack core, bound to the top level.
module rsd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("accepted word did not arrive");
endmodule

bind raw_sample_to_double_unpack_core rsd_checker u_rsd_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

>>> verif/tb_raw_sample_to_double_unpack_core.sv
// Testbench for the raw sample to binary64 unpack core: directed table, then random words.
module tb_raw_sample_to_double_unpack_core;
    import rsd_pkg::*;

    localparam int TIMEOUT_CYCLES = 400000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] EXP_ALL1 = 64'h7FF0_0000_0000_0000;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;     // raw_word[63:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;     // value_bits[63:0]
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [3:0]  cfg_wdata;

    logic [3:0]  cur_size;
    logic        cur_float;
    logic [63:0] expected_bits[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off_cycles;
    bit          hold_off_go;
    bit          hold_off_seen;

    raw_sample_to_double_unpack_core dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("Some tests failed");
        $finish;
    end

    // sign * mag * 2^scale, rounded to nearest even
    function automatic logic [63:0] scaled_to_double(input logic neg, input logic [63:0] mag,
                                                     input int scale);
        int          top;
        int          ex;
        int          sh;
        logic [63:0] keep;
        logic [63:0] rem;
        logic [63:0] half;
        top = 0;
        if (mag == 0) return neg ? SIGN64 : 64'd0;
        for (int i = 0; i < 64; i++) if (mag[i]) top = i;
        ex = 1023 + top + scale;
        if (top <= 52) begin
            keep = mag << (52 - top);
        end else begin
            sh = top - 52;
            rem = mag & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            keep = mag >> sh;
            if (rem > half || (rem == half && keep[0])) begin
                keep = keep + 64'd1;
                if (keep == (64'd1 << 53)) begin
                    keep = keep >> 1;
                    ex = ex + 1;
                end
            end
        end
        return {neg, ex[10:0], keep[51:0]};
    endfunction

    function automatic logic [63:0] signed_to_double(input logic [63:0] w, input int bits);
        logic [63:0] mask;
        logic [63:0] v;
        logic [63:0] mag;
        mask = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
        v = w & mask;
        if (v[bits-1]) begin
            mag = (~v + 64'd1) & mask;
            if (mag == 0) mag = 64'd1 << (bits - 1);
            return scaled_to_double(1'b1, mag, 0);
        end
        return scaled_to_double(1'b0, v, 0);
    endfunction

    function automatic logic [63:0] half_to_double(input logic [15:0] h);
        if (h[14:10] == 0) return scaled_to_double(h[15], {54'd0, h[9:0]}, -24);
        return scaled_to_double(h[15], {53'd0, 1'b1, h[9:0]}, int'(h[14:10]) - 25);
    endfunction

    function automatic logic [63:0] single_to_double(input logic [31:0] f);
        logic [63:0] s;
        s = f[31] ? SIGN64 : 64'd0;
        if (f[30:23] == 8'hFF) begin
            if (f[22:0] == 0) return s | EXP_ALL1;
            return s | EXP_ALL1 | (64'd1 << 51) | ({41'd0, f[22:0]} << 29);
        end
        if (f[30:23] == 0) return scaled_to_double(f[31], {41'd0, f[22:0]}, -149);
        return scaled_to_double(f[31], {40'd0, 1'b1, f[22:0]}, int'(f[30:23]) - 150);
    endfunction

    function automatic logic [63:0] unpack_sample(input logic [63:0] w);
        if (cur_float) begin
            case (cur_size)
                SIZE_2B: return half_to_double(w[15:0]);
                SIZE_4B: return single_to_double(w[31:0]);
                SIZE_8B: return w;
                default: return 64'd0;
            endcase
        end
        case (cur_size)
            SIZE_1B: return signed_to_double(w, 8);
            SIZE_2B: return signed_to_double(w, 16);
            SIZE_4B: return signed_to_double(w, 32);
            SIZE_8B: return signed_to_double(w, 64);
            default: return 64'd0;
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_WORD_SIZE) cur_size = val;
        else if (idx == REG_IS_FLOAT) cur_float = val[0];
        @(posedge aclk);
    endtask

    // drop valid and wait until every expected word has come
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_bits.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // optionally idle first, then push the expectation and offer the word until taken; valid stays up
    task automatic send_word(input logic [63:0] w, input bit typed, input logic [63:0] want);
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99, 0) < send_idle_pct) @(posedge aclk);
        end
        expected_bits.push_back(typed ? want : unpack_sample(w));
        s_tvalid <= 1'b1;
        s_tdata <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [63:0] random_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(5, 0))
            0: w = w >> $urandom_range(63, 0);
            1: w = ~(w >> $urandom_range(63, 0));
            2: w[14:10] = $urandom_range(1, 0) ? 5'h1F : 5'h00;
            3: w[30:23] = $urandom_range(1, 0) ? 8'hFF : 8'h00;
            default: ;
        endcase
        return w;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_off_cycles <= 0;
            hold_off_seen <= hold_off_go;
        end else if (hold_off_go != hold_off_seen) begin
            hold_off_seen <= hold_off_go;
            hold_off_cycles <= HOLD_OFF_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", m_tdata);
            end else begin
                if (m_tdata !== expected_bits[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("value_bits mismatch: expected %h actual %h",
                                 expected_bits[0], m_tdata);
                end
                void'(expected_bits.pop_front());
            end
        end
    end

    typedef struct {
        logic [3:0]  size;
        logic        flt;
        logic [63:0] word;
        bit          typed;
        logic [63:0] want;
    } dir_row_t;

    dir_row_t dir_rows[] = '{
        '{SIZE_2B, 1'b0, 64'h0000_0000_0000_0001, 1, 64'h3FF0_0000_0000_0000},
        '{SIZE_1B, 1'b0, 64'hFFFF_FFFF_FFFF_FF80, 1, 64'hC060_0000_0000_0000},
        '{SIZE_1B, 1'b0, 64'h0000_0000_0000_007F, 0, 64'd0},
        '{SIZE_1B, 1'b0, 64'h0000_0000_0000_0000, 1, 64'h0000_0000_0000_0000},
        '{SIZE_2B, 1'b0, 64'h0000_0000_0000_8000, 1, 64'hC0E0_0000_0000_0000},
        '{SIZE_4B, 1'b0, 64'h0000_0000_8000_0000, 1, 64'hC1E0_0000_0000_0000},
        '{SIZE_4B, 1'b0, 64'hFFFF_FFFF_7FFF_FFFF, 0, 64'd0},
        '{SIZE_8B, 1'b0, 64'h8000_0000_0000_0000, 1, 64'hC3E0_0000_0000_0000},
        '{SIZE_8B, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 1, 64'h43E0_0000_0000_0000},
        '{SIZE_8B, 1'b0, 64'h0020_0000_0000_0001, 0, 64'd0},
        '{SIZE_8B, 1'b0, 64'h0020_0000_0000_0003, 0, 64'd0},
        '{SIZE_8B, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'hBFF0_0000_0000_0000},
        '{SIZE_2B, 1'b1, 64'h0000_0000_0000_0000, 1, 64'h0000_0000_0000_0000},
        '{SIZE_2B, 1'b1, 64'h0000_0000_0000_8000, 1, 64'h8000_0000_0000_0000},
        '{SIZE_2B, 1'b1, 64'h0000_0000_0000_0001, 0, 64'd0},
        '{SIZE_2B, 1'b1, 64'h0000_0000_0000_7FFF, 0, 64'd0},
        '{SIZE_2B, 1'b1, 64'h0000_0000_0000_FC00, 0, 64'd0},
        '{SIZE_4B, 1'b1, 64'h0000_0000_7F80_0000, 1, 64'h7FF0_0000_0000_0000},
        '{SIZE_4B, 1'b1, 64'h0000_0000_FFC0_0001, 0, 64'd0},
        '{SIZE_4B, 1'b1, 64'h0000_0000_0000_0001, 0, 64'd0},
        '{SIZE_8B, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'hFFFF_FFFF_FFFF_FFFF},
        '{SIZE_1B, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h0000_0000_0000_0000},
        '{4'd15,   1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h0000_0000_0000_0000},
        '{4'd0,    1'b1, 64'h1234_5678_9ABC_DEF0, 1, 64'h0000_0000_0000_0000}
    };

    initial begin
        logic [3:0] sizes[] = '{SIZE_1B, SIZE_2B, SIZE_4B, SIZE_8B, 4'd0, 4'd3, 4'd15};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cur_size = WORD_SIZE_RESET;
        cur_float = 1'b0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].size != cur_size || dir_rows[i].flt != cur_float) begin
                drain();
                write_reg(REG_WORD_SIZE, dir_rows[i].size);
                write_reg(REG_IS_FLOAT, {3'd0, dir_rows[i].flt});
            end
            send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
        end
        // index beyond the last register: ignored
        drain();
        write_reg(2'd3, 4'd1);
        write_reg(2'd2, 4'd1);
        send_word(64'h0000_0000_0000_00FF, 0, 64'd0);

        // long receiver hold-off while words keep coming
        drain();
        write_reg(REG_WORD_SIZE, SIZE_8B);
        write_reg(REG_IS_FLOAT, 4'd0);
        hold_off_go = ~hold_off_go;
        repeat (12) send_word(random_word(), 0, 64'd0);

        for (int ph = 0; ph < 22; ph++) begin
            idle_mode_e mode;
            mode = idle_mode_e'(ph % 4);
            drain();
            send_idle_pct = (mode == IDLE_SEND || mode == IDLE_BOTH) ? 86 : 0;
            recv_idle_pct = (mode == IDLE_RECV || mode == IDLE_BOTH) ? 86 : 0;
            if (mode == IDLE_BOTH) begin
                send_idle_pct = 23;
                recv_idle_pct = 23;
            end
            // mostly valid formats, a few unsupported ones
            write_reg(REG_WORD_SIZE,
                      sizes[$urandom_range(6, 0) % ($urandom_range(3, 0) == 0 ? 7 : 4)]);
            write_reg(REG_IS_FLOAT, 4'($urandom_range(1, 0)));
            repeat (24) send_word(random_word(), 0, 64'd0);
        end

        drain();
        if (mismatches == 0 && expected_bits.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
